// ===== rtl/nmea_sentence_framer_top_defines.svh =====
// ----------------------------------------------------------------------------
// nmea sentence framer assertion macros
// shared property templates for the framer checks
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NSF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nsf check failed");

// next-cycle implication, disabled in reset
`define NSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nsf check failed");

`endif

// ===== rtl/nsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_pkg
// shared types and constants of the nmea sentence framer
// ----------------------------------------------------------------------------
package nsf_pkg;

   localparam int NUM_TYPES = 6;

   // byte classes handed from front to back
   localparam logic [2:0] KIND_OTHER  = 3'd0;
   localparam logic [2:0] KIND_DOLLAR = 3'd1;
   localparam logic [2:0] KIND_COMMA  = 3'd2;
   localparam logic [2:0] KIND_STAR   = 3'd3;
   localparam logic [2:0] KIND_CR     = 3'd4;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_FIELD = 2'd1;
   localparam logic [1:0] EV_GOOD  = 2'd2;
   localparam logic [1:0] EV_BAD   = 2'd3;

   localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
   localparam logic [2:0] TYPE_GSV     = 3'd4;
   localparam logic [2:0] TYPE_VTG     = 3'd6;

   localparam logic [5:0] FIELD_MAX     = 6'd63;
   localparam logic [5:0] REQ_MASK_INIT = 6'h3F;

   // sentence type patterns in precedence order
   localparam logic [23:0] PATTERNS [NUM_TYPES] = '{
      "GGA", "GSA", "RMC", "GSV", "GLL", "VTG"
   };

   // two-entry queues
   localparam logic [1:0] QUEUE_FULL = 2'd2;

   typedef struct packed {
      logic [2:0]           kind;
      logic [7:0]           ch;
      logic                 dec_ok;
      logic [3:0]           dec_digit;
      logic                 hex_ok;
      logic [3:0]           hex_digit;
      logic [NUM_TYPES-1:0] tail_hits;
   } item_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [2:0]  sentence_type;
      logic [5:0]  field_index;
      logic [15:0] field_decimal;
      logic [7:0]  body_checksum;
      logic        set_complete;
   } result_type;

endpackage

// ===== rtl/nsf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_front
// classifies received bytes and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module nsf_front import nsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   item_type   cls;
   item_type   q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;

   always_comb begin
      cls.ch = req_rx_byte;
      priority if (req_rx_byte == CH_DOLLAR) begin
         cls.kind = KIND_DOLLAR;
      end else if (req_rx_byte == CH_COMMA) begin
         cls.kind = KIND_COMMA;
      end else if (req_rx_byte == CH_STAR) begin
         cls.kind = KIND_STAR;
      end else if (req_rx_byte == CH_CR) begin
         cls.kind = KIND_CR;
      end else begin
         cls.kind = KIND_OTHER;
      end
      cls.dec_ok    = (req_rx_byte >= "0") && (req_rx_byte <= "9");
      cls.dec_digit = req_rx_byte[3:0];
      cls.hex_ok    = cls.dec_ok
                   || ((req_rx_byte >= "A") && (req_rx_byte <= "F"))
                   || ((req_rx_byte >= "a") && (req_rx_byte <= "f"));
      // letters a-f sit at low nibble 1..6 in both cases
      cls.hex_digit = cls.dec_ok ? req_rx_byte[3:0] : req_rx_byte[3:0] + 4'd9;
      for (int i = 0; i < NUM_TYPES; i++) begin
         cls.tail_hits[i] = (req_rx_byte == PATTERNS[i][7:0]);
      end
   end

   assign req_full   = (count_ff == QUEUE_FULL);
   assign push_ok    = req_push && !req_full;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   always_comb begin
      wr_in    = push_ok ? ~wr_ff : wr_ff;
      rd_in    = item_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push_ok} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/nsf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsf_back
// sentence state update and two-entry result queue
// ----------------------------------------------------------------------------
module nsf_back import nsf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [5:0] required_mask,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output result_type rsp_head
);

   logic        after_star_ff, after_star_in;
   logic [5:0]  field_count_ff, field_count_in;
   logic [2:0]  current_type_ff, current_type_in;
   logic [7:0]  running_xor_ff, running_xor_in;
   logic [7:0]  hex_acc_ff, hex_acc_in;
   logic        hex_stopped_ff, hex_stopped_in;
   logic [15:0] dec_acc_ff, dec_acc_in;
   logic        dec_stopped_ff, dec_stopped_in;
   logic        dollar_ff, dollar_in;
   logic [15:0] last_two_ff, last_two_in;
   logic [5:0]  type_hits_ff, type_hits_in;
   logic [7:0]  gsv_total_ff, gsv_total_in;
   logic [7:0]  gsv_current_ff, gsv_current_in;
   logic [5:0]  seen_mask_ff, seen_mask_in;

   logic [19:0] dec_wide;
   logic [5:0]  seen_next;
   logic [1:0]  ev;
   logic        done;
   result_type  res;

   result_type  q_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  count_ff;
   logic        step;
   logic        pop_ok;

   assign step     = item_valid && (count_ff != QUEUE_FULL);
   assign item_pop = step;
   assign pop_ok   = rsp_pop && !rsp_empty;
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_head  = q_ff[rd_ff];

   // acc * 10 + digit, at most 20 bits
   assign dec_wide = ({4'd0, dec_acc_ff} << 3) + ({4'd0, dec_acc_ff} << 1)
                   + {16'd0, item.dec_digit};

   always_comb begin
      after_star_in   = after_star_ff;
      field_count_in  = field_count_ff;
      current_type_in = current_type_ff;
      running_xor_in  = running_xor_ff;
      hex_acc_in      = hex_acc_ff;
      hex_stopped_in  = hex_stopped_ff;
      dec_acc_in      = dec_acc_ff;
      dec_stopped_in  = dec_stopped_ff;
      dollar_in       = dollar_ff;
      last_two_in     = last_two_ff;
      type_hits_in    = type_hits_ff;
      gsv_total_in    = gsv_total_ff;
      gsv_current_in  = gsv_current_ff;
      seen_mask_in    = seen_mask_ff;
      seen_next       = seen_mask_ff;
      ev              = EV_NONE;
      done            = 1'b0;

      if (step) begin
         unique case (item.kind)
            KIND_DOLLAR: begin
               after_star_in   = 1'b0;
               field_count_in  = 6'd0;
               current_type_in = TYPE_UNKNOWN;
               running_xor_in  = 8'd0;
               hex_acc_in      = 8'd0;
               hex_stopped_in  = 1'b0;
               dec_acc_in      = 16'd0;
               dec_stopped_in  = 1'b0;
               dollar_in       = 1'b1;
               last_two_in     = 16'd0;
               type_hits_in    = 6'd0;
               gsv_total_in    = 8'd0;
               gsv_current_in  = 8'd0;
            end
            KIND_COMMA, KIND_STAR: begin
               if ((field_count_ff == 6'd0) && dollar_ff) begin
                  // first pattern in precedence order wins
                  current_type_in = TYPE_UNKNOWN;
                  for (int i = NUM_TYPES - 1; i >= 0; i--) begin
                     if (type_hits_ff[i]) begin
                        current_type_in = 3'(i + 1);
                     end
                  end
               end else if (current_type_ff == TYPE_GSV) begin
                  if (field_count_ff == 6'd1) begin
                     gsv_total_in = dec_acc_ff[7:0];
                  end else if (field_count_ff == 6'd2) begin
                     gsv_current_in = dec_acc_ff[7:0];
                  end
               end
               if (item.kind == KIND_STAR) begin
                  after_star_in = 1'b1;
               end else if (!after_star_ff) begin
                  running_xor_in = running_xor_ff ^ item.ch;
               end
               ev             = EV_FIELD;
               hex_acc_in     = 8'd0;
               hex_stopped_in = 1'b0;
               dec_acc_in     = 16'd0;
               dec_stopped_in = 1'b0;
               if (field_count_ff != FIELD_MAX) begin
                  field_count_in = field_count_ff + 6'd1;
               end
            end
            KIND_CR: begin
               if (running_xor_ff == hex_acc_ff) begin
                  ev = EV_GOOD;
                  if ((current_type_ff != TYPE_UNKNOWN) && (current_type_ff <= TYPE_VTG)
                      && ((current_type_ff != TYPE_GSV) || (gsv_current_ff == gsv_total_ff)))
                  begin
                     seen_next = seen_mask_ff | (6'd1 << (current_type_ff - 3'd1));
                  end
                  if ((seen_next & required_mask) == required_mask) begin
                     seen_mask_in = 6'd0;
                     done         = 1'b1;
                  end else begin
                     seen_mask_in = seen_next;
                  end
               end else begin
                  ev = EV_BAD;
               end
            end
            KIND_OTHER: begin
               if (!after_star_ff) begin
                  running_xor_in = running_xor_ff ^ item.ch;
               end
               if (field_count_ff == 6'd0) begin
                  for (int i = 0; i < NUM_TYPES; i++) begin
                     if ((last_two_ff[15:8] == PATTERNS[i][23:16])
                         && (last_two_ff[7:0] == PATTERNS[i][15:8])
                         && item.tail_hits[i]) begin
                        type_hits_in[i] = 1'b1;
                     end
                  end
                  last_two_in = {last_two_ff[7:0], item.ch};
               end
               if (!dec_stopped_ff) begin
                  if (item.dec_ok) begin
                     dec_acc_in = (dec_wide[19:16] != 4'd0) ? 16'hFFFF : dec_wide[15:0];
                  end else begin
                     dec_stopped_in = 1'b1;
                  end
               end
               if (!hex_stopped_ff) begin
                  if (item.hex_ok) begin
                     hex_acc_in = {hex_acc_ff[3:0], item.hex_digit};
                  end else begin
                     hex_stopped_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      res.event_res     = ev;
      res.sentence_type = current_type_in;
      res.field_index   = (ev == EV_FIELD) ? field_count_ff : field_count_in;
      res.field_decimal = (ev == EV_FIELD) ? dec_acc_ff : dec_acc_in;
      res.body_checksum = running_xor_in;
      res.set_complete  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_star_ff   <= 1'b0;
         field_count_ff  <= 6'd0;
         current_type_ff <= TYPE_UNKNOWN;
         running_xor_ff  <= 8'd0;
         hex_acc_ff      <= 8'd0;
         hex_stopped_ff  <= 1'b0;
         dec_acc_ff      <= 16'd0;
         dec_stopped_ff  <= 1'b0;
         dollar_ff       <= 1'b0;
         last_two_ff     <= 16'd0;
         type_hits_ff    <= 6'd0;
         gsv_total_ff    <= 8'd0;
         gsv_current_ff  <= 8'd0;
         seen_mask_ff    <= 6'd0;
         wr_ff           <= 1'b0;
         rd_ff           <= 1'b0;
         count_ff        <= 2'd0;
      end else begin
         after_star_ff   <= after_star_in;
         field_count_ff  <= field_count_in;
         current_type_ff <= current_type_in;
         running_xor_ff  <= running_xor_in;
         hex_acc_ff      <= hex_acc_in;
         hex_stopped_ff  <= hex_stopped_in;
         dec_acc_ff      <= dec_acc_in;
         dec_stopped_ff  <= dec_stopped_in;
         dollar_ff       <= dollar_in;
         last_two_ff     <= last_two_in;
         type_hits_ff    <= type_hits_in;
         gsv_total_ff    <= gsv_total_in;
         gsv_current_ff  <= gsv_current_in;
         seen_mask_ff    <= seen_mask_in;
         wr_ff           <= step ? ~wr_ff : wr_ff;
         rd_ff           <= pop_ok ? ~rd_ff : rd_ff;
         count_ff        <= count_ff + {1'b0, step} - {1'b0, pop_ok};
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         q_ff[wr_ff] <= res;
      end
   end

endmodule

// ===== rtl/nmea_sentence_framer_top.sv =====
`timescale 1ns / 1ps
// A received NMEA byte is taken every clock while req_full is low; it is
// registered in the front queue, processed by the combinational sentence
// update in the back part, and its result is written into the result queue
// when the back part steps. Sustained rate is one byte per clock while
// results are popped; every byte gives exactly one result.
// When results are not popped the back part stops once its two-entry queue is
// full, and req_full rises once the two-entry front queue is full as well.
// csr_ready is always high and the mask should be written only while idle.
// ----------------------------------------------------------------------------
// nmea_sentence_framer_top
// nmea 0183 sentence framer: field split, checksum and type set tracking
// ----------------------------------------------------------------------------
`include "nmea_sentence_framer_top_defines.svh"

module nmea_sentence_framer_top import nsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_event_res,
   output logic [2:0]  rsp_sentence_type,
   output logic [5:0]  rsp_field_index,
   output logic [15:0] rsp_field_decimal,
   output logic [7:0]  rsp_body_checksum,
   output logic        rsp_set_complete,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_required_mask
);

   logic       [5:0] required_mask_ff;
   logic       item_valid;
   item_type   item;
   logic       item_pop;
   result_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         required_mask_ff <= REQ_MASK_INIT;
      end else if (csr_valid && csr_ready) begin
         required_mask_ff <= csr_required_mask;
      end
   end

   nsf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   nsf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .required_mask (required_mask_ff),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_head      (head)
   );

   assign rsp_event_res     = head.event_res;
   assign rsp_sentence_type = head.sentence_type;
   assign rsp_field_index   = head.field_index;
   assign rsp_field_decimal = head.field_decimal;
   assign rsp_body_checksum = head.body_checksum;
   assign rsp_set_complete  = head.set_complete;

   // an accepted request is visible to the back part in the next cycle
   `NSF_ASSERT_NEXT(a_front_fill, clock, reset, req_push && !req_full, item_valid)
   // a back step always leaves a result waiting
   `NSF_ASSERT_NEXT(a_back_fill, clock, reset, item_pop, !rsp_empty)
   // completion only comes with a good checksum
   `NSF_ASSERT_NOW(a_done_good, clock, reset, !rsp_empty && rsp_set_complete, rsp_event_res == EV_GOOD)

endmodule

// ===== tb/sv/nmea_sentence_framer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker
// Watches the request, response and csr channels of the sentence framer.
// Every accepted request byte is run through a local model of the framer and
// queued as an expected response. Each popped response is compared field by
// field with the oldest one in that queue.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_checker import nsf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_event_res,
   input  logic [2:0]  rsp_sentence_type,
   input  logic [5:0]  rsp_field_index,
   input  logic [15:0] rsp_field_decimal,
   input  logic [7:0]  rsp_body_checksum,
   input  logic        rsp_set_complete,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [5:0]  csr_required_mask,
   output int          fail_count,
   output int          results_due
);

   logic [5:0]  need_mask;
   logic [5:0]  seen_types;
   logic [5:0]  pattern_hits;
   logic        past_star;
   logic        from_dollar;
   logic        dec_done;
   logic        hex_done;
   logic [5:0]  field_no;
   logic [2:0]  cur_type;
   logic [7:0]  body_xor;
   logic [7:0]  hex_val;
   logic [7:0]  gsv_count;
   logic [7:0]  gsv_part;
   logic [15:0] dec_val;
   logic [15:0] prev_chars;
   result_type  expected_q [$];
   result_type  want;
   result_type  got;

   function automatic void restart_sentence();
      past_star    = 1'b0;
      field_no     = '0;
      cur_type     = TYPE_UNKNOWN;
      body_xor     = '0;
      hex_val      = '0;
      hex_done     = 1'b0;
      dec_val      = '0;
      dec_done     = 1'b0;
      prev_chars   = '0;
      pattern_hits = '0;
      gsv_count    = '0;
      gsv_part     = '0;
   endfunction

   // advances the sentence state by one byte and returns its response
   function automatic result_type frame_byte(input logic [7:0] c);
      result_type  r;
      logic [1:0]  ev;
      logic        done;
      logic [5:0]  idx;
      logic [15:0] dval;
      logic [4:0]  nib;
      int unsigned grown;
      int          i;
      ev   = EV_NONE;
      done = 1'b0;
      idx  = field_no;
      dval = dec_val;
      if (c == CH_DOLLAR) begin
         restart_sentence();
         from_dollar = 1'b1;
      end else if (c == CH_COMMA || c == CH_STAR) begin
         if (field_no == 0 && from_dollar) begin
            // lowest pattern bit wins
            cur_type = TYPE_UNKNOWN;
            for (i = NUM_TYPES - 1; i >= 0; i--)
               if (pattern_hits[i]) cur_type = 3'(i + 1);
         end else if (cur_type == TYPE_GSV) begin
            if (field_no == 1) gsv_count = dec_val[7:0];
            else if (field_no == 2) gsv_part = dec_val[7:0];
         end
         if (c == CH_STAR) past_star = 1'b1;
         else if (!past_star) body_xor ^= c;
         ev       = EV_FIELD;
         hex_val  = '0;
         hex_done = 1'b0;
         dec_val  = '0;
         dec_done = 1'b0;
         if (field_no < FIELD_MAX) field_no++;
      end else if (c == CH_CR) begin
         if (body_xor == hex_val) begin
            ev = EV_GOOD;
            if (cur_type != TYPE_UNKNOWN && cur_type <= TYPE_VTG &&
                (cur_type != TYPE_GSV || gsv_part == gsv_count))
               seen_types[cur_type - 1] = 1'b1;
            if ((seen_types & need_mask) == need_mask) begin
               seen_types = '0;
               done       = 1'b1;
            end
         end else begin
            ev = EV_BAD;
         end
      end else begin
         if (!past_star) body_xor ^= c;
         if (field_no == 0) begin
            case ({prev_chars, c})
               "GGA":   pattern_hits[0] = 1'b1;
               "GSA":   pattern_hits[1] = 1'b1;
               "RMC":   pattern_hits[2] = 1'b1;
               "GSV":   pattern_hits[3] = 1'b1;
               "GLL":   pattern_hits[4] = 1'b1;
               "VTG":   pattern_hits[5] = 1'b1;
               default: ;
            endcase
            prev_chars = {prev_chars[7:0], c};
         end
         if (!dec_done) begin
            if (c >= "0" && c <= "9") begin
               grown   = dec_val * 10 + (c - "0");
               dec_val = (grown > 65535) ? 16'hFFFF : grown[15:0];
            end else begin
               dec_done = 1'b1;
            end
         end
         if (!hex_done) begin
            nib = 5'h10;
            if (c >= "0" && c <= "9") nib = 5'(c - "0");
            else if (c >= "A" && c <= "F") nib = 5'(c - "A" + 10);
            else if (c >= "a" && c <= "f") nib = 5'(c - "a" + 10);
            if (nib[4]) hex_done = 1'b1;
            else hex_val = {hex_val[3:0], nib[3:0]};
         end
      end
      if (ev != EV_FIELD) begin
         idx  = field_no;
         dval = dec_val;
      end
      r = {ev, cur_type, idx, dval, body_xor, done};
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         restart_sentence();
         from_dollar = 1'b0;
         seen_types  = '0;
         need_mask   = REQ_MASK_INIT;
         expected_q.delete();
         fail_count  = 0;
         results_due = 0;
      end else begin
         if (csr_valid && csr_ready) need_mask = csr_required_mask;
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_event_res, rsp_sentence_type, rsp_field_index,
                   rsp_field_decimal, rsp_body_checksum, rsp_set_complete};
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no request pending: ev=%0d type=%0d",
                           $time, got.event_res, got.sentence_type);
            end else begin
               want = expected_q.pop_front();
               if (got.event_res !== want.event_res ||
                   got.sentence_type !== want.sentence_type ||
                   got.field_index !== want.field_index ||
                   got.field_decimal !== want.field_decimal ||
                   got.body_checksum !== want.body_checksum ||
                   got.set_complete !== want.set_complete) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch exp ev=%0d type=%0d idx=%0d dec=%0d xor=%02h done=%0d",
                              $time, want.event_res, want.sentence_type, want.field_index,
                              want.field_decimal, want.body_checksum, want.set_complete);
                     $display("%0t:          got ev=%0d type=%0d idx=%0d dec=%0d xor=%02h done=%0d",
                              $time, got.event_res, got.sentence_type, got.field_index,
                              got.field_decimal, got.body_checksum, got.set_complete);
                  end
               end
            end
         end
         if (req_push && !req_full) expected_q.push_back(frame_byte(req_rx_byte));
         results_due = expected_q.size();
      end
   end

endmodule

// ===== tb/sv/nmea_sentence_framer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_framer_top_tb
// Feeds the framer a short directed byte stream, then random NMEA sentences
// (good, corrupted, truncated) mixed with noise bytes under several required
// masks. Both channels idle at random and the response side holds off long
// enough to back up the request side. The checker does the comparing.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_top_tb;
   import nsf_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_rx_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_event_res;
   logic [2:0]  rsp_sentence_type;
   logic [5:0]  rsp_field_index;
   logic [15:0] rsp_field_decimal;
   logic [7:0]  rsp_body_checksum;
   logic        rsp_set_complete;
   logic        csr_valid;
   logic        csr_ready;
   logic [5:0]  csr_required_mask;
   int          fail_count;
   int          results_due;
   int          sent_count = 0;
   int          tx_gap_max = 4;
   logic [7:0]  line_q [$];
   string       type_names [6] = '{"GGA", "GSA", "RMC", "GSV", "GLL", "VTG"};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   nmea_sentence_framer_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_res     (rsp_event_res),
      .rsp_sentence_type (rsp_sentence_type),
      .rsp_field_index   (rsp_field_index),
      .rsp_field_decimal (rsp_field_decimal),
      .rsp_body_checksum (rsp_body_checksum),
      .rsp_set_complete  (rsp_set_complete),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_required_mask (csr_required_mask)
   );

   nmea_sentence_framer_checker frame_chk (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_res     (rsp_event_res),
      .rsp_sentence_type (rsp_sentence_type),
      .rsp_field_index   (rsp_field_index),
      .rsp_field_decimal (rsp_field_decimal),
      .rsp_body_checksum (rsp_body_checksum),
      .rsp_set_complete  (rsp_set_complete),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_required_mask (csr_required_mask),
      .fail_count        (fail_count),
      .results_due       (results_due)
   );

   // starts and ends at a falling edge; push stays high when no gap follows
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic send_line();
      while (line_q.size() != 0) send_byte(line_q.pop_front());
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   task automatic add_upper(input int n);
      repeat (n) line_q.push_back(8'($urandom_range("A", "Z")));
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 10) return "0" + n;
      return 8'((lower ? "a" : "A") + n - 10);
   endfunction

   // xor of the body, star, two or three hex digits and carriage return
   task automatic finish_sentence(input bit may_corrupt);
      logic [7:0] sum;
      bit         lower;
      int         j;
      sum = '0;
      for (j = 1; j < line_q.size(); j++) sum ^= line_q[j];
      line_q.push_back(CH_STAR);
      if (may_corrupt && $urandom_range(0, 7) == 0) sum ^= 8'($urandom_range(1, 255));
      lower = 1'($urandom_range(0, 1));
      // an extra leading digit shifts out of the 8-bit hex value
      if ($urandom_range(0, 9) == 0)
         line_q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
      line_q.push_back(hex_char(sum[7:4], lower));
      line_q.push_back(hex_char(sum[3:0], lower));
      line_q.push_back(CH_CR);
   endtask

   task automatic build_sentence(input bit broken);
      int pick;
      int nfields;
      int len;
      int total;
      int i;
      int keep;
      logic [7:0] ch;
      line_q.push_back(CH_DOLLAR);
      add_upper(2);
      pick = $urandom_range(0, 7);
      if (pick < 6) begin
         add_text(type_names[pick]);
      end else if (pick == 6) begin
         add_upper(3);
      end else begin
         add_text(type_names[$urandom_range(0, 5)]);
         add_text(type_names[$urandom_range(0, 5)]);
      end
      if ($urandom_range(0, 5) == 0) add_upper(1);
      if (pick == 3) begin
         total = $urandom_range(1, 3);
         if ($urandom_range(0, 7) == 0) total = $urandom_range(0, 600);
         add_text($sformatf(",%0d,%0d", total, $urandom_range(1, 3)));
      end
      nfields = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 8);
      repeat (nfields) begin
         line_q.push_back(CH_COMMA);
         case ($urandom_range(0, 3))
            0: ;
            1: begin
               len = $urandom_range(1, 7);
               repeat (len) line_q.push_back(8'("0" + $urandom_range(0, 9)));
               if ($urandom_range(0, 3) == 0) add_text(".5");
            end
            2: begin
               len = $urandom_range(1, 4);
               repeat (len) line_q.push_back(hex_char(4'($urandom_range(0, 15)),
                                                      1'($urandom_range(0, 1))));
            end
            default: begin
               len = $urandom_range(1, 5);
               repeat (len) begin
                  ch = 8'($urandom_range(32, 126));
                  if (ch == CH_DOLLAR || ch == CH_COMMA || ch == CH_STAR) ch = "_";
                  line_q.push_back(ch);
               end
            end
         endcase
      end
      finish_sentence(1'b1);
      if ($urandom_range(0, 5) == 0) line_q.push_back(CH_CR);
      if ($urandom_range(0, 1) == 0) line_q.push_back("\n");
      if (broken) begin
         keep = $urandom_range(1, line_q.size() - 1);
         for (i = line_q.size(); i > keep; i--) void'(line_q.pop_back());
      end
   endtask

   // csr writes only once every response is back
   task automatic write_mask(input logic [5:0] m);
      req_push <= 1'b0;
      wait (results_due == 0);
      repeat (4) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_required_mask <= m;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [5:0] mask_plan [6];
      int         phase;
      int         phase_end;
      int         pick;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_rx_byte       = '0;
      csr_valid         = 1'b0;
      csr_required_mask = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bytes before any dollar, zero and all-ones bytes, comma after star,
      // repeated carriage return, then the last part of a gsv sentence
      tx_gap_max = 0;
      line_q = '{8'h00, 8'hFF, "7", "a", CH_COMMA, CH_STAR, CH_COMMA, CH_CR, CH_CR};
      send_line();
      add_text("$GPGSV,2,2,08");
      finish_sentence(1'b0);
      send_line();

      mask_plan = '{REQ_MASK_INIT, 6'h00, 6'h08, 6'h05, 6'($urandom_range(0, 63)),
                    REQ_MASK_INIT};
      for (phase = 0; phase < 6; phase++) begin
         write_mask(mask_plan[phase]);
         phase_end = sent_count + 280;
         while (sent_count < phase_end) begin
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
            pick = $urandom_range(0, 19);
            if (pick < 2)
               repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
            else build_sentence(pick == 2);
            send_line();
         end
      end

      req_push <= 1'b0;
      wait (results_due == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("nmea_sentence_framer_top_tb: done, clean");
      else
         $display("nmea_sentence_framer_top_tb: done, errors");
      $finish;
   end

   // response side: random gaps, bursts, and two long hold-offs
   initial begin
      int gap;
      int popped;
      int rx_gap_max;
      rsp_pop    = 1'b0;
      popped     = 0;
      rx_gap_max = 4;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if (popped % 64 == 0) rx_gap_max = $urandom_range(0, 1) * 4;
         gap = $urandom_range(0, rx_gap_max);
         if (popped == 500 || popped == 1200) gap += 150;
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
         popped++;
      end
   end

   initial begin
      #500000;
      $display("nmea_sentence_framer_top_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/nsf_pkg.sv
rtl/nsf_front.sv
rtl/nsf_back.sv
rtl/nmea_sentence_framer_top.sv
tb/sv/nmea_sentence_framer_checker.sv
tb/sv/nmea_sentence_framer_top_tb.sv
